// ----- sv/mchw_pkg.sv -----
// Shared types and constants for the multi-channel heartbeat watchdog.
// Request and response payloads, table entry layout, command and state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mchw_pkg;

	localparam int DEPTH = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int TOTAL_W = ADDR_W + 1;

	localparam logic [7:0] STRIKE_MAX = 8'd255;
	localparam logic [7:0] KILL_THR_RESET = 8'd3;
	localparam logic [7:0] PANIC_THR_RESET = 8'd5;

	localparam logic CFG_KILL_THR = 1'b0;
	localparam logic CFG_PANIC_THR = 1'b1;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_PONG     = 2'd1,
		CMD_TICK     = 2'd2
	} cmd_t;

	localparam logic [1:0] KIND_REG_ACK = 2'd0;
	localparam logic [1:0] KIND_PONG_ACK = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PONG_RD,
		ST_TICK_RD,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] now_time;
		logic [4:0]  entry_index;
		logic [31:0] process_id;
		logic [63:0] deadline;
		logic        vital;
	} in_req_t;

	typedef struct packed {
		logic [1:0]  report_kind;
		logic [4:0]  slot;
		logic        accepted;
		logic        overdue;
		logic [7:0]  strikes;
		logic        kill;
		logic        panic;
		logic [31:0] owner_pid;
		logic        last;
	} out_rsp_t;

	typedef struct packed {
		logic [63:0] last_seen;
		logic [63:0] allowed_silence;
		logic [31:0] owner_id;
		logic [7:0]  strikes;
		logic        vital;
	} entry_t;

	typedef struct packed {
		logic       overdue;
		logic [7:0] strikes;
		logic       kill;
		logic       panic;
	} eval_t;

endpackage

`default_nettype wire

// ----- sv/mchw_eval.sv -----
// Per-entry tick evaluation: wrapped age against deadline, strike update,
// kill and panic flags. Depends on mchw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mchw_eval (
	input  var mchw_pkg::entry_t entry,
	input  var logic [63:0]      now_time,
	input  var logic [7:0]       kill_thr,
	input  var logic [7:0]       panic_thr,
	output mchw_pkg::eval_t      result
);

	logic [63:0] age;
	logic        late;
	logic [7:0]  strikes_next;

	assign age = now_time - entry.last_seen;
	assign late = age > entry.allowed_silence;

	always_comb begin
		if (!late) begin
			strikes_next = 8'd0;
		end else if (entry.strikes == mchw_pkg::STRIKE_MAX) begin
			strikes_next = mchw_pkg::STRIKE_MAX;
		end else begin
			strikes_next = entry.strikes + 8'd1;
		end
		result.overdue = late;
		result.strikes = strikes_next;
		result.kill = late && (strikes_next >= kill_thr);
		result.panic = late && entry.vital && (strikes_next >= panic_thr);
	end

endmodule

`default_nettype wire

// ----- sv/multi_channel_heartbeat_watchdog_core.sv -----
// Multi-channel heartbeat watchdog: entry table in one synchronous memory.
// Depends on mchw_pkg and mchw_eval.
//
// Usage:
//   in channel (in_valid / in_stall / in_req) takes one request at a time:
//   register, pong or tick. out channel (out_valid / out_stall / out_rsp)
//   returns the reports; the final report of a request carries last.
//   Register: the ack passes through the holding register to the output register.
//   Pong: memory read, then read-modify-write alongside the ack.
//   Tick: one report per table entry, one per cycle while the output register
//   is not stalled, paced by the single memory read port. A tick on an
//   empty table and an unused command give no report and leave the core idle.
//   in_stall is high from acceptance until the last report is loaded into
//   the output register, so a new request can enter while that report waits.
//   A stalled output register freezes the walk; a finished report is parked
//   in a holding register and released when the receiver takes the prior one.
//   Reset empties the table (entry count zero) and restores the thresholds to
//   kill 3 and panic 5; memory contents are not cleared.
//   cfg_we / cfg_index / cfg_data write a threshold.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_heartbeat_watchdog_core (
	input  var logic               clk,
	input  var logic               arst_n,
	input  var logic               in_valid,
	output logic                   in_stall,
	input  var mchw_pkg::in_req_t  in_req,
	output logic                   out_valid,
	input  var logic               out_stall,
	output mchw_pkg::out_rsp_t     out_rsp,
	input  var logic               cfg_we,
	input  var logic               cfg_index,
	input  var logic [7:0]         cfg_data
);

	mchw_pkg::entry_t mem [mchw_pkg::DEPTH];
	mchw_pkg::entry_t rd_data_s1;

	mchw_pkg::state_t state_q, state_d;
	logic [mchw_pkg::TOTAL_W-1:0] total_q;
	logic [mchw_pkg::ADDR_W-1:0]  cnt_q, cnt_d;
	logic                         more_q, more_d;
	logic [7:0]                   kill_thr_q, panic_thr_q;
	mchw_pkg::in_req_t            req_q;
	mchw_pkg::out_rsp_t           hold_q, rsp;
	mchw_pkg::out_rsp_t           out_q;
	logic                         out_valid_q;

	logic                         in_fire, out_free, full, present, tick_last;
	logic                         total_inc, hold_we, load_out, load_hold;
	logic                         mem_we, rd_en;
	logic [mchw_pkg::ADDR_W-1:0]  mem_waddr, rd_addr;
	mchw_pkg::entry_t             mem_wdata;
	mchw_pkg::eval_t              ev;

	mchw_eval u_eval (
		.entry     (rd_data_s1),
		.now_time  (req_q.now_time),
		.kill_thr  (kill_thr_q),
		.panic_thr (panic_thr_q),
		.result    (ev)
	);

	assign in_stall = (state_q != mchw_pkg::ST_IDLE);
	assign in_fire = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign full = (total_q >= mchw_pkg::TOTAL_W'(mchw_pkg::DEPTH));
	assign present = ({1'b0, in_req.entry_index} < total_q);
	assign tick_last = (({1'b0, cnt_q} + 1'b1) == total_q);
	assign out_valid = out_valid_q;
	assign out_rsp = out_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		more_d = more_q;
		total_inc = 1'b0;
		hold_we = 1'b0;
		load_out = 1'b0;
		load_hold = 1'b0;
		mem_we = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = rd_data_s1;
		rd_en = 1'b0;
		rd_addr = cnt_q + mchw_pkg::ADDR_W'(1);
		rsp = '0;
		rsp.last = 1'b1;
		unique case (state_q)
			mchw_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_req.cmd)
						mchw_pkg::CMD_REGISTER: begin
							rsp.report_kind = mchw_pkg::KIND_REG_ACK;
							if (!full) begin
								mem_we = 1'b1;
								mem_waddr = total_q[mchw_pkg::ADDR_W-1:0];
								mem_wdata.last_seen = in_req.now_time;
								mem_wdata.allowed_silence = in_req.deadline;
								mem_wdata.owner_id = in_req.process_id;
								mem_wdata.strikes = 8'd0;
								mem_wdata.vital = in_req.vital;
								total_inc = 1'b1;
								rsp.slot = total_q[mchw_pkg::ADDR_W-1:0];
								rsp.accepted = 1'b1;
								rsp.owner_pid = in_req.process_id;
							end
							hold_we = 1'b1;
							more_d = 1'b0;
							state_d = mchw_pkg::ST_HOLD;
						end
						mchw_pkg::CMD_PONG: begin
							if (present) begin
								rd_en = 1'b1;
								rd_addr = in_req.entry_index;
								state_d = mchw_pkg::ST_PONG_RD;
							end else begin
								rsp.report_kind = mchw_pkg::KIND_PONG_ACK;
								rsp.slot = in_req.entry_index;
								hold_we = 1'b1;
								more_d = 1'b0;
								state_d = mchw_pkg::ST_HOLD;
							end
						end
						mchw_pkg::CMD_TICK: begin
							if (total_q != '0) begin
								rd_en = 1'b1;
								rd_addr = '0;
								cnt_d = '0;
								state_d = mchw_pkg::ST_TICK_RD;
							end
						end
						default: ;
					endcase
				end
			end
			mchw_pkg::ST_PONG_RD: begin
				mem_we = 1'b1;
				mem_waddr = req_q.entry_index;
				mem_wdata.last_seen = req_q.now_time;
				mem_wdata.strikes = 8'd0;
				rsp.report_kind = mchw_pkg::KIND_PONG_ACK;
				rsp.slot = req_q.entry_index;
				rsp.accepted = 1'b1;
				rsp.owner_pid = rd_data_s1.owner_id;
				if (out_free) begin
					load_out = 1'b1;
					state_d = mchw_pkg::ST_IDLE;
				end else begin
					hold_we = 1'b1;
					more_d = 1'b0;
					state_d = mchw_pkg::ST_HOLD;
				end
			end
			mchw_pkg::ST_TICK_RD: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata.strikes = ev.strikes;
				rsp.report_kind = mchw_pkg::KIND_TICK;
				rsp.slot = cnt_q;
				rsp.accepted = 1'b1;
				rsp.overdue = ev.overdue;
				rsp.strikes = ev.strikes;
				rsp.kill = ev.kill;
				rsp.panic = ev.panic;
				rsp.owner_pid = rd_data_s1.owner_id;
				rsp.last = tick_last;
				if (out_free) begin
					load_out = 1'b1;
					if (tick_last) begin
						state_d = mchw_pkg::ST_IDLE;
					end else begin
						rd_en = 1'b1;
						cnt_d = cnt_q + mchw_pkg::ADDR_W'(1);
					end
				end else begin
					hold_we = 1'b1;
					more_d = !tick_last;
					state_d = mchw_pkg::ST_HOLD;
				end
			end
			mchw_pkg::ST_HOLD: begin
				if (out_free) begin
					load_hold = 1'b1;
					if (more_q) begin
						rd_en = 1'b1;
						cnt_d = cnt_q + mchw_pkg::ADDR_W'(1);
						state_d = mchw_pkg::ST_TICK_RD;
					end else begin
						state_d = mchw_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = mchw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mchw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			cnt_q <= '0;
			more_q <= 1'b0;
			out_valid_q <= 1'b0;
			kill_thr_q <= mchw_pkg::KILL_THR_RESET;
			panic_thr_q <= mchw_pkg::PANIC_THR_RESET;
		end else begin
			if (total_inc) begin
				total_q <= total_q + 1'b1;
			end
			cnt_q <= cnt_d;
			more_q <= more_d;
			if (load_out || load_hold) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					mchw_pkg::CFG_KILL_THR:  kill_thr_q <= cfg_data;
					mchw_pkg::CFG_PANIC_THR: panic_thr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_req;
		end
		if (hold_we) begin
			hold_q <= rsp;
		end
		if (load_out) begin
			out_q <= rsp;
		end else if (load_hold) begin
			out_q <= hold_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/mchw_checker.sv -----
// Port-level checks for the heartbeat watchdog core, bound to the top level.
// Depends on mchw_pkg and multi_channel_heartbeat_watchdog_core.
`timescale 1ns / 1ps
`default_nettype none

module mchw_checker (
	input var logic               clk,
	input var logic               arst_n,
	input var logic               in_stall,
	input var logic               out_valid,
	input var logic               out_stall,
	input var mchw_pkg::out_rsp_t out_rsp
);

	logic out_fire;
	assign out_fire = out_valid && !out_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_rsp))
		else $error("stalled report changed or dropped");

	a_ack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_rsp.report_kind != mchw_pkg::KIND_TICK |->
		!out_rsp.overdue && !out_rsp.kill && !out_rsp.panic &&
		out_rsp.strikes == 8'd0 && out_rsp.last)
		else $error("ack carries tick fields");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_rsp.report_kind == mchw_pkg::KIND_REG_ACK && !out_rsp.accepted |->
		out_rsp.slot == '0 && out_rsp.owner_pid == '0)
		else $error("refused register ack not zeroed");

	a_tick_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_rsp.report_kind == mchw_pkg::KIND_TICK |->
		out_rsp.accepted && (out_rsp.overdue || (!out_rsp.kill && !out_rsp.panic &&
		out_rsp.strikes == 8'd0)))
		else $error("tick report flags inconsistent");

	a_no_req_mid_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !out_rsp.last |-> in_stall)
		else $error("request taken while a tick walk is open");

endmodule

bind multi_channel_heartbeat_watchdog_core mchw_checker u_mchw_checker (.*);

`default_nettype wire

// ----- test/multi_channel_heartbeat_watchdog_core_tb.sv -----
// Testbench for multi_channel_heartbeat_watchdog_core: directed, strike saturation, random
// and back-pressure requests, each report checked against an in-bench model of the table.
// Depends on mchw_pkg and the core RTL.
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog_core_tb;
	import mchw_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef logic [ADDR_W-1:0] slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_req_t in_req = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_rsp_t out_rsp;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	multi_channel_heartbeat_watchdog_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted watchdog table
	logic [7:0] kill_level;
	logic [7:0] panic_level;
	int entry_count;
	logic [63:0] seen_at [DEPTH];
	logic [63:0] silence_limit [DEPTH];
	logic [31:0] owner_tab [DEPTH];
	logic [7:0] strike_tab [DEPTH];
	logic vital_tab [DEPTH];

	out_rsp_t pending_reports [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	logic [63:0] wall_clock;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected report, expected none, actual %h", $time, out_rsp);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				compare_field("report_kind", want.report_kind, out_rsp.report_kind);
				compare_field("slot", want.slot, out_rsp.slot);
				compare_field("accepted", want.accepted, out_rsp.accepted);
				compare_field("overdue", want.overdue, out_rsp.overdue);
				compare_field("strikes", want.strikes, out_rsp.strikes);
				compare_field("kill", want.kill, out_rsp.kill);
				compare_field("panic", want.panic, out_rsp.panic);
				compare_field("owner_pid", want.owner_pid, out_rsp.owner_pid);
				compare_field("last", want.last, out_rsp.last);
			end
		end
	end

	function automatic out_rsp_t make_report(logic [1:0] kind, slot_t slot, logic acc,
			logic od, logic [7:0] st, logic kl, logic pn, logic [31:0] pid, logic fin);
		out_rsp_t r;
		r.report_kind = kind;
		r.slot = slot;
		r.accepted = acc;
		r.overdue = od;
		r.strikes = st;
		r.kill = kl;
		r.panic = pn;
		r.owner_pid = pid;
		r.last = fin;
		return r;
	endfunction

	function automatic void predict_reports(in_req_t r);
		logic [63:0] age;
		logic od;
		logic kl;
		logic pn;
		int i;
		case (r.cmd)
			CMD_REGISTER: begin
				if (entry_count >= DEPTH) begin
					pending_reports.push_back(make_report(KIND_REG_ACK, '0, 1'b0, 1'b0, 8'd0,
						1'b0, 1'b0, 32'd0, 1'b1));
				end else begin
					seen_at[entry_count] = r.now_time;
					silence_limit[entry_count] = r.deadline;
					owner_tab[entry_count] = r.process_id;
					strike_tab[entry_count] = 8'd0;
					vital_tab[entry_count] = r.vital;
					pending_reports.push_back(make_report(KIND_REG_ACK, slot_t'(entry_count),
						1'b1, 1'b0, 8'd0, 1'b0, 1'b0, r.process_id, 1'b1));
					entry_count++;
				end
			end
			CMD_PONG: begin
				if (int'(r.entry_index) < entry_count) begin
					seen_at[r.entry_index] = r.now_time;
					strike_tab[r.entry_index] = 8'd0;
					pending_reports.push_back(make_report(KIND_PONG_ACK, r.entry_index, 1'b1,
						1'b0, 8'd0, 1'b0, 1'b0, owner_tab[r.entry_index], 1'b1));
				end else begin
					pending_reports.push_back(make_report(KIND_PONG_ACK, r.entry_index, 1'b0,
						1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 1'b1));
				end
			end
			CMD_TICK: begin
				for (i = 0; i < entry_count; i++) begin
					age = r.now_time - seen_at[i];
					od = 1'b0;
					kl = 1'b0;
					pn = 1'b0;
					if (age > silence_limit[i]) begin
						od = 1'b1;
						if (strike_tab[i] != STRIKE_MAX)
							strike_tab[i] = strike_tab[i] + 8'd1;
						kl = (strike_tab[i] >= kill_level);
						pn = vital_tab[i] && (strike_tab[i] >= panic_level);
					end else begin
						strike_tab[i] = 8'd0;
					end
					pending_reports.push_back(make_report(KIND_TICK, slot_t'(i), 1'b1, od,
						strike_tab[i], kl, pn, owner_tab[i], (i + 1 == entry_count)));
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic in_req_t make_request(logic [1:0] cmd, logic [63:0] now, slot_t idx,
			logic [31:0] pid, logic [63:0] dl, logic vit);
		in_req_t r;
		r.cmd = cmd;
		r.now_time = now;
		r.entry_index = idx;
		r.process_id = pid;
		r.deadline = dl;
		r.vital = vit;
		return r;
	endfunction

	function automatic logic [63:0] random_word64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(in_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_reports(r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic idx, logic [7:0] level);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= level;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KILL_THR)
			kill_level = level;
		else
			panic_level = level;
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	task automatic send_random_request();
		in_req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			r.cmd = CMD_REGISTER;
		else if (pick < 65)
			r.cmd = CMD_PONG;
		else if (pick < 95)
			r.cmd = CMD_TICK;
		else
			r.cmd = CMD_UNUSED;
		wall_clock = wall_clock + 64'($urandom_range(0, 400));
		r.now_time = ($urandom_range(99) < 10) ? random_word64() : wall_clock;
		if (r.cmd == CMD_PONG && entry_count > 0 && $urandom_range(99) < 85)
			r.entry_index = slot_t'($urandom_range(0, entry_count - 1));
		else
			r.entry_index = slot_t'($urandom_range(31));
		r.process_id = $urandom;
		pick = $urandom_range(99);
		if (pick < 80)
			r.deadline = 64'($urandom_range(0, 1500));
		else if (pick < 90)
			r.deadline = '1;
		else
			r.deadline = random_word64();
		r.vital = $urandom_range(1);
		send_request(r);
	endtask

	task automatic test_directed();
		set_idling(37, 65);
		send_request(make_request(CMD_TICK, 64'd0, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_UNUSED, '1, '1, '1, '1, 1'b1));
		send_request(make_request(CMD_PONG, 64'd0, 5'd0, '0, '0, 1'b0));
		send_request(make_request(CMD_PONG, 64'd0, 5'd31, '0, '0, 1'b0));
		send_request(make_request(CMD_REGISTER, 64'd0, '0, 32'd0, 64'd0, 1'b1));
		send_request(make_request(CMD_REGISTER, '1, '0, '1, '1, 1'b0));
		send_request(make_request(CMD_REGISTER, 64'd100, '0, 32'h1234_5678, 64'd50, 1'b1));
		// wrapped age on slot 2; deadline edge on the next two ticks
		send_request(make_request(CMD_TICK, 64'd0, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd151, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd150, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd1000, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd2000, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd3000, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd4000, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_PONG, 64'd5000, 5'd0, '0, '0, 1'b0));
		send_request(make_request(CMD_PONG, 64'd4000, 5'd2, '1, '1, 1'b1));
		send_request(make_request(CMD_PONG, 64'd4000, 5'd3, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, 64'd5000, '0, '0, '0, 1'b0));
		send_request(make_request(CMD_REGISTER, 64'd5000, '1, 32'hA5A5_A5A5,
			64'h5A5A_5A5A_5A5A_5A5A, 1'b0));
		send_request(make_request(CMD_PONG, 64'd6000, 5'd31, '0, '0, 1'b0));
		send_request(make_request(CMD_TICK, '1, '0, '0, '0, 1'b0));
	endtask

	// enough overdue ticks to pin the strike count at its ceiling
	task automatic test_strike_saturation();
		int n;
		write_threshold(CFG_KILL_THR, 8'd255);
		write_threshold(CFG_PANIC_THR, 8'd255);
		for (n = 0; n < 258; n++) begin
			if (n == 0)
				set_idling(37, 65);
			else if (n == 129)
				set_idling(65, 37);
			send_request(make_request(CMD_TICK, random_word64(), slot_t'($urandom_range(31)),
				$urandom, random_word64(), 1'($urandom_range(1))));
		end
	endtask

	task automatic test_random_traffic();
		set_idling(65, 37);
		write_threshold(CFG_KILL_THR, 8'd1);
		write_threshold(CFG_PANIC_THR, 8'd1);
		repeat (50) send_random_request();
		write_threshold(CFG_KILL_THR, 8'($urandom_range(1, 255)));
		write_threshold(CFG_PANIC_THR, 8'($urandom_range(1, 255)));
		repeat (50) send_random_request();
		set_idling(0, 0);
		write_threshold(CFG_KILL_THR, 8'd1);
		write_threshold(CFG_PANIC_THR, 8'd255);
		repeat (45) send_random_request();
		write_threshold(CFG_KILL_THR, 8'd255);
		write_threshold(CFG_PANIC_THR, 8'd1);
		repeat (45) send_random_request();
	endtask

	task automatic test_backpressure();
		write_threshold(CFG_KILL_THR, 8'($urandom_range(1, 255)));
		write_threshold(CFG_PANIC_THR, 8'($urandom_range(1, 255)));
		set_idling(0, 0);
		hold_request = HOLD_OFF_CYCLES;
		repeat (4) begin
			wall_clock = wall_clock + 64'd700;
			send_request(make_request(CMD_TICK, wall_clock, '0, '0, '0, 1'b0));
			send_request(make_request(CMD_PONG, wall_clock, slot_t'($urandom_range(31)),
				'0, '0, 1'b0));
		end
	endtask

	initial begin
		kill_level = KILL_THR_RESET;
		panic_level = PANIC_THR_RESET;
		entry_count = 0;
		wall_clock = 64'hFFFF_FFFF_FFFF_F000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_strike_saturation();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
